// ===== hw/rtl/wgcs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wgcs_pkg: shared types and constants
// Widths, function codes and the sequencer state type of the grid sampler.
// ----------------------------------------------------------------------------
package wgcs_pkg;

  localparam int BOARD_SIZE_DEF  = 11;
  localparam int WEIGHT_BITS_DEF = 16;
  localparam int IDX_W           = 4;
  localparam int FIELD_W         = 16;
  localparam int TOTAL_W         = 24;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  typedef enum logic [1:0] {
    FUNC_LOAD   = 2'd0,
    FUNC_OCCUPY = 2'd1,
    FUNC_SAMPLE = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_RD    = 8'b0000_0010,
    ST_WR    = 8'b0000_0100,
    ST_MUL   = 8'b0000_1000,
    ST_ROWS  = 8'b0001_0000,
    ST_CELLS = 8'b0010_0000,
    ST_OUT   = 8'b0100_0000,
    ST_RCHK  = 8'b1000_0000
  } state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/wgcs_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wgcs_in_if / wgcs_out_if: valid/ready channels
// Input command channel and result channel of the grid sampler.
// ----------------------------------------------------------------------------
interface wgcs_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [3:0] row_index;
  logic [3:0] col_index;
  logic [15:0] load_weight;
  logic [15:0] weight_up_right;
  logic [15:0] weight_right;
  logic [15:0] weight_down;
  logic [15:0] weight_down_left;
  logic [15:0] weight_left;
  logic [15:0] weight_up;
  logic [15:0] random_fraction;
  modport source (output valid, func, row_index, col_index, load_weight,
                  weight_up_right, weight_right, weight_down, weight_down_left,
                  weight_left, weight_up, random_fraction, input ready);
  modport sink (input valid, func, row_index, col_index, load_weight,
                weight_up_right, weight_right, weight_down, weight_down_left,
                weight_left, weight_up, random_fraction, output ready);
endinterface

interface wgcs_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  sample_row;
  logic [3:0]  sample_col;
  logic        sample_found;
  logic [23:0] total_weight;
  modport source (output valid, sample_row, sample_col, sample_found,
                  total_weight, input ready);
  modport sink (input valid, sample_row, sample_col, sample_found,
                total_weight, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/wgcs_cell_mem.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wgcs_cell_mem: cell weight and free-flag memory
// One write port, one registered read port. Per-cell valid bits make a cell
// that was never written read as weight zero and free.
// ----------------------------------------------------------------------------
module wgcs_cell_mem #(
  parameter int CELLS  = 121,
  parameter int WBITS  = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic [$clog2(CELLS)-1:0] rd_addr,
  output logic      [WBITS-1:0]         rd_weight,
  output logic                          rd_free,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(CELLS)-1:0] wr_addr,
  input  wire logic [WBITS-1:0]         wr_weight,
  input  wire logic                     wr_free
);
  logic [WBITS:0]   mem [CELLS];
  logic [CELLS-1:0] vld_r;
  logic [WBITS:0]   rdata_r;
  logic             rvld_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= {wr_free, wr_weight};
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rvld_r <= 1'b0;
    end else begin
      if (wr_en) vld_r[wr_addr] <= 1'b1;
      rvld_r <= vld_r[rd_addr];
    end
  end

  assign rd_weight = rvld_r ? rdata_r[WBITS-1:0] : '0;
  assign rd_free   = rvld_r ? rdata_r[WBITS] : 1'b1;
endmodule
`default_nettype wire

// ===== hw/rtl/weighted_grid_cell_sampler.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// weighted_grid_cell_sampler: two-level weighted cell picker on a hex grid
// Keeps cell weights, free flags, row sums and a total; loads, occupies and
// draws weighted samples.
// ----------------------------------------------------------------------------
// One word in gives one word out. Cell state lives in a single-port-write,
// registered-read memory, so every cell touch is a read-modify-write. The
// center cell takes a read and a write step, and each neighbour adds a check
// step in front of them. A load passes the accept, read, write and output
// steps; an occupy runs the center and then each neighbour before its output
// step, and a neighbour that falls off the grid takes only its check step. A
// sample takes the accept step, a multiply step, up to BOARD_SIZE row steps,
// a fetch step plus up to BOARD_SIZE cell compares, and the output step. A
// sample on a zero total goes from the multiply step to the output step, and
// an off-grid load or occupy or the unused function code goes from accept
// straight to the output step. The row walk and cell walk, one element per
// cycle, set the sample time. A result that waits in the output register
// holds the sequencer in its output step. After reset every cell reads as
// free with zero weight through per-cell valid bits; no clearing pass runs.
module weighted_grid_cell_sampler #(
  parameter int BOARD_SIZE  = wgcs_pkg::BOARD_SIZE_DEF,
  parameter int WEIGHT_BITS = wgcs_pkg::WEIGHT_BITS_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  wgcs_in_if.sink    in_ch,
  wgcs_out_if.source out_ch
);
  localparam int CELLS = BOARD_SIZE * BOARD_SIZE;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = $clog2(BOARD_SIZE);
  localparam int SUM_W = WEIGHT_BITS + $clog2(BOARD_SIZE + 1) + 1;
  localparam int TOT_W = WEIGHT_BITS + $clog2(CELLS + 1) + 1;
  localparam int IW    = wgcs_pkg::IDX_W;

  wgcs_pkg::state_t state_r, state_nxt;

  // Latched command.
  logic [1:0]            func_r;
  logic [IW-1:0]         row_r, col_r;
  logic [15:0]           nw_r [7];
  logic [15:0]           frac_r;
  logic [2:0]            step_r;        // 0 = center, 1..6 neighbours
  logic signed [IW+1:0]  tr_r, tc_r;    // current target cell
  logic [SUM_W-1:0]      row_sum_r [BOARD_SIZE];
  logic [TOT_W-1:0]      total_r;
  logic [TOT_W+15:0]     t_r;
  logic [TOT_W+15:0]     prod;
  logic [RW-1:0]         wr_r;          // walk row / col
  logic [RW-1:0]         wc_r;

  // Output register.
  logic                  ovld_r;
  logic [IW-1:0]         orow_r, ocol_r;
  logic                  ofound_r;
  logic [wgcs_pkg::TOTAL_W-1:0] otot_r;

  logic [AW-1:0]      rd_addr, wr_addr;
  logic [WEIGHT_BITS-1:0] rd_w, wr_w;
  logic               rd_free, wr_en, wr_free;

  wgcs_cell_mem #(.CELLS(CELLS), .WBITS(WEIGHT_BITS)) u_mem (
    .clk, .rst_n, .rd_addr, .rd_weight(rd_w), .rd_free,
    .wr_en, .wr_addr, .wr_weight(wr_w), .wr_free
  );

  // Neighbour offsets for steps 1..6.
  function automatic logic signed [2:0] dro(input logic [2:0] s);
    case (s)
      3'd1, 3'd6: dro = -3'sd1;
      3'd3, 3'd4: dro = 3'sd1;
      default:    dro = 3'sd0;
    endcase
  endfunction
  function automatic logic signed [2:0] dco(input logic [2:0] s);
    case (s)
      3'd1, 3'd2: dco = 3'sd1;
      3'd4, 3'd5: dco = -3'sd1;
      default:    dco = 3'sd0;
    endcase
  endfunction

  logic in_go;
  assign in_ch.ready = (state_r == wgcs_pkg::ST_IDLE);
  assign in_go = in_ch.valid && in_ch.ready;

  logic on_grid_in;
  assign on_grid_in = (32'(in_ch.row_index) < BOARD_SIZE) &&
                      (32'(in_ch.col_index) < BOARD_SIZE);

  logic target_ok;
  assign target_ok = (tr_r >= 0) && (tc_r >= 0) &&
                     (32'(tr_r) < BOARD_SIZE) && (32'(tc_r) < BOARD_SIZE);

  logic [AW-1:0] tgt_addr, walk_addr;
  assign tgt_addr  = AW'(32'(tr_r) * BOARD_SIZE + 32'(tc_r));
  assign walk_addr = AW'(32'(wr_r) * BOARD_SIZE + 32'(wc_r));
  assign rd_addr   = (state_r == wgcs_pkg::ST_CELLS || state_r == wgcs_pkg::ST_ROWS)
                     ? walk_addr : tgt_addr;

  // Scaled sample target: fraction times total, a 16 x TOT_W product.
  assign prod = (TOT_W+16)'(frac_r) * (TOT_W+16)'(total_r);

  // New weight of the current target.
  logic [WEIGHT_BITS-1:0] new_w;
  always_comb begin
    if (func_r == 2'(wgcs_pkg::FUNC_LOAD))
      new_w = WEIGHT_BITS'(nw_r[0]);
    else if (step_r == 3'd0 || !rd_free)
      new_w = '0;
    else
      new_w = WEIGHT_BITS'(nw_r[step_r]);
  end

  assign wr_en   = (state_r == wgcs_pkg::ST_WR);
  assign wr_addr = tgt_addr;
  assign wr_w    = new_w;
  assign wr_free = (func_r == 2'(wgcs_pkg::FUNC_OCCUPY) && step_r == 3'd0)
                   ? 1'b0 : rd_free;

  logic last_step;
  assign last_step = (func_r != 2'(wgcs_pkg::FUNC_OCCUPY)) || (step_r == 3'd6);

  logic [RW-1:0] last_idx;
  assign last_idx = RW'(BOARD_SIZE - 1);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      wgcs_pkg::ST_IDLE: begin
        if (in_go) begin
          if (in_ch.func == 2'(wgcs_pkg::FUNC_SAMPLE)) state_nxt = wgcs_pkg::ST_MUL;
          else if ((in_ch.func == 2'(wgcs_pkg::FUNC_LOAD) ||
                    in_ch.func == 2'(wgcs_pkg::FUNC_OCCUPY)) && on_grid_in)
            state_nxt = wgcs_pkg::ST_RD;
          else state_nxt = wgcs_pkg::ST_OUT;
        end
      end
      wgcs_pkg::ST_RCHK: state_nxt = target_ok ? wgcs_pkg::ST_RD
                                   : (step_r == 3'd6 ? wgcs_pkg::ST_OUT
                                                     : wgcs_pkg::ST_RCHK);
      wgcs_pkg::ST_RD:  state_nxt = wgcs_pkg::ST_WR;
      wgcs_pkg::ST_WR:  state_nxt = last_step ? wgcs_pkg::ST_OUT : wgcs_pkg::ST_RCHK;
      wgcs_pkg::ST_MUL: state_nxt = (total_r == '0) ? wgcs_pkg::ST_OUT
                                                    : wgcs_pkg::ST_ROWS;
      wgcs_pkg::ST_ROWS: begin
        if (t_r < (TOT_W+16)'(row_sum_r[wr_r]) || wr_r == last_idx)
          state_nxt = wgcs_pkg::ST_CELLS;
      end
      wgcs_pkg::ST_CELLS: begin
        // rd data for wc_r-1 valid when step_r[0] set
        if (step_r[0] && t_r < (TOT_W+16)'(rd_w))
          state_nxt = wgcs_pkg::ST_OUT;
        else if (step_r[0] && wc_r == last_idx && !step_r[1])
          state_nxt = state_r;
        else if (step_r[1])
          state_nxt = wgcs_pkg::ST_OUT;
      end
      wgcs_pkg::ST_OUT: if (!ovld_r || out_ch.ready) state_nxt = wgcs_pkg::ST_IDLE;
      default: state_nxt = wgcs_pkg::ST_IDLE;
    endcase
  end

  // Column being compared in the cell walk is the one read last cycle.
  logic [RW-1:0] cmp_col;
  assign cmp_col = wc_r - RW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wgcs_pkg::ST_IDLE;
      total_r <= '0;
      for (int i = 0; i < BOARD_SIZE; i++) row_sum_r[i] <= '0;
      ovld_r  <= 1'b0;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == wgcs_pkg::ST_OUT && (!ovld_r || out_ch.ready)) ovld_r <= 1'b1;
      else if (out_ch.ready) ovld_r <= 1'b0;
      case (state_r)
        wgcs_pkg::ST_IDLE: if (in_go) begin
          func_r <= in_ch.func;
          row_r  <= in_ch.row_index;
          col_r  <= in_ch.col_index;
          tr_r   <= (IW+2)'(in_ch.row_index);
          tc_r   <= (IW+2)'(in_ch.col_index);
          nw_r[0] <= in_ch.load_weight;
          nw_r[1] <= in_ch.weight_up_right;
          nw_r[2] <= in_ch.weight_right;
          nw_r[3] <= in_ch.weight_down;
          nw_r[4] <= in_ch.weight_down_left;
          nw_r[5] <= in_ch.weight_left;
          nw_r[6] <= in_ch.weight_up;
          frac_r <= in_ch.random_fraction;
          step_r <= '0;
        end
        wgcs_pkg::ST_RCHK: if (!target_ok && step_r != 3'd6) begin
          step_r <= step_r + 3'd1;
          tr_r <= (IW+2)'($signed({2'b0, row_r})) + (IW+2)'(dro(step_r + 3'd1));
          tc_r <= (IW+2)'($signed({2'b0, col_r})) + (IW+2)'(dco(step_r + 3'd1));
        end
        wgcs_pkg::ST_WR: begin
          row_sum_r[RW'(tr_r)] <= row_sum_r[RW'(tr_r)] - SUM_W'(rd_w) + SUM_W'(new_w);
          total_r <= total_r - TOT_W'(rd_w) + TOT_W'(new_w);
          if (!last_step) begin
            step_r <= step_r + 3'd1;
            tr_r <= (IW+2)'($signed({2'b0, row_r})) + (IW+2)'(dro(step_r + 3'd1));
            tc_r <= (IW+2)'($signed({2'b0, col_r})) + (IW+2)'(dco(step_r + 3'd1));
          end
        end
        wgcs_pkg::ST_MUL: begin
          t_r  <= prod >> 16;
          wr_r <= '0;
          wc_r <= '0;
          step_r <= '0;
        end
        wgcs_pkg::ST_ROWS: begin
          if (t_r < (TOT_W+16)'(row_sum_r[wr_r]) || wr_r == last_idx) begin
            wc_r <= '0;
            step_r <= '0;
          end else begin
            t_r  <= t_r - (TOT_W+16)'(row_sum_r[wr_r]);
            wr_r <= wr_r + RW'(1);
          end
        end
        wgcs_pkg::ST_CELLS: begin
          // step_r[0]: read data present; step_r[1]: last column forced.
          if (!step_r[0]) begin
            step_r[0] <= 1'b1;
            wc_r <= wc_r + RW'(1);
          end else if (t_r < (TOT_W+16)'(rd_w)) begin
            wc_r <= cmp_col;
          end else begin
            t_r <= t_r - (TOT_W+16)'(rd_w);
            if (wc_r == last_idx) step_r[1] <= 1'b1;
            else wc_r <= wc_r + RW'(1);
          end
        end
        wgcs_pkg::ST_OUT: if (!ovld_r || out_ch.ready) begin
          ofound_r <= (func_r == 2'(wgcs_pkg::FUNC_SAMPLE)) && (total_r != '0);
          orow_r   <= (func_r == 2'(wgcs_pkg::FUNC_SAMPLE) && total_r != '0)
                      ? IW'(wr_r) : '0;
          ocol_r   <= (func_r == 2'(wgcs_pkg::FUNC_SAMPLE) && total_r != '0)
                      ? (step_r[1] ? IW'(last_idx) : IW'(wc_r)) : '0;
          otot_r   <= (64'(total_r) > 64'(wgcs_pkg::TOTAL_MAX)) ? wgcs_pkg::TOTAL_MAX
                      : wgcs_pkg::TOTAL_W'(total_r);
        end
        default: ;
      endcase
    end
  end

  assign out_ch.valid        = ovld_r;
  assign out_ch.sample_row   = orow_r;
  assign out_ch.sample_col   = ocol_r;
  assign out_ch.sample_found = ofound_r;
  assign out_ch.total_weight = otot_r;

  // The input side is only open while the sequencer is idle.
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> state_r == wgcs_pkg::ST_IDLE) else $error("ready outside idle");
  // A memory write happens only in the write step.
  a_wr_state: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> state_r == wgcs_pkg::ST_WR) else $error("stray write");
  // An accepted word always moves the sequencer out of idle.
  a_go: assert property (@(posedge clk) disable iff (!rst_n)
    in_go |=> state_r != wgcs_pkg::ST_IDLE) else $error("lost command");
endmodule
`default_nettype wire
